[hdl/wav_riff_pcm16_stream_parser_assert.svh]
// Assertion macros for the WAV stream parser.
// Used by the top level; expects clk and rst in scope.
`ifndef WAV_RIFF_PCM16_STREAM_PARSER_ASSERT_SVH
`define WAV_RIFF_PCM16_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication
`define WRP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define WRP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/wrp_pkg.sv]
// Shared constants, status codes and command struct for the WAV parser.
// No dependencies.
package wrp_pkg;

  localparam int PosW = 33;
  localparam int ExtW = PosW + 34;
  localparam logic [PosW-1:0] PosMax = '1;

  localparam logic [31:0] TagRiff = 32'h46464952;
  localparam logic [31:0] TagWave = 32'h45564157;
  localparam logic [31:0] TagFmt  = 32'h20746D66;
  localparam logic [31:0] TagData = 32'h61746164;
  localparam int HeaderBytes = 12;
  localparam int FmtMinBytes = 16;
  localparam logic [15:0] PcmCode = 16'd1;
  localparam logic [15:0] SampleBits = 16'd16;

  // Register indexes
  localparam logic [2:0] REG_MAX_FILE = 3'd0;
  localparam logic [2:0] REG_MAX_DATA = 3'd1;
  localparam logic [2:0] REG_MAX_CH   = 3'd2;
  localparam logic [2:0] REG_MIN_RATE = 3'd3;
  localparam logic [2:0] REG_MAX_RATE = 3'd4;

  // Status codes
  localparam logic [4:0] ST_OK         = 5'd0;
  localparam logic [4:0] ST_LIMITS     = 5'd1;
  localparam logic [4:0] ST_TOO_LONG   = 5'd2;
  localparam logic [4:0] ST_TOO_SHORT  = 5'd3;
  localparam logic [4:0] ST_NO_RIFF    = 5'd4;
  localparam logic [4:0] ST_NO_WAVE    = 5'd5;
  localparam logic [4:0] ST_SIZE_OVF   = 5'd6;
  localparam logic [4:0] ST_TRUNC      = 5'd7;
  localparam logic [4:0] ST_RIFF_SMALL = 5'd8;
  localparam logic [4:0] ST_CHUNK_OVER = 5'd9;
  localparam logic [4:0] ST_FMT_TWICE  = 5'd10;
  localparam logic [4:0] ST_FMT_SHORT  = 5'd11;
  localparam logic [4:0] ST_DATA_TWICE = 5'd12;
  localparam logic [4:0] ST_DATA_BIG   = 5'd13;
  localparam logic [4:0] ST_PAD_OVER   = 5'd14;
  localparam logic [4:0] ST_NO_FMT     = 5'd15;
  localparam logic [4:0] ST_NOT_PCM    = 5'd16;
  localparam logic [4:0] ST_BITS       = 5'd17;
  localparam logic [4:0] ST_CHANNELS   = 5'd18;
  localparam logic [4:0] ST_RATE       = 5'd19;
  localparam logic [4:0] ST_ALIGN      = 5'd20;
  localparam logic [4:0] ST_BYTE_RATE  = 5'd21;
  localparam logic [4:0] ST_NO_DATA    = 5'd22;
  localparam logic [4:0] ST_DATA_EMPTY = 5'd23;
  localparam logic [4:0] ST_DATA_ALIGN = 5'd24;

  // Chunk kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic chk_load;
    logic div_step;
    logic emit;
  } wrp_cmd_t;

endpackage

[hdl/wrp_ctrl.sv]
// Controller for the WAV parser: byte intake, end-of-file check sequence.
// Depends on wrp_pkg.
module wrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  input  logic              out_free,
  output logic              s_tready,
  output wrp_pkg::wrp_cmd_t cmd
);

  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0] state, state_next;
  logic [4:0] cnt;

  // Handshake and commands
  always_comb begin
    s_tready     = (state == S_RUN) && out_free;
    cmd.accept   = s_tready && s_tvalid;
    cmd.chk_load = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.emit     = (state == S_FIN) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_RUN: if (cmd.accept && s_tlast) state_next = S_MUL;
      S_MUL: state_next = S_DIV;
      S_DIV: if (cnt == '1) state_next = S_FIN;
      S_FIN: if (out_free) state_next = S_RUN;
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) cnt <= cnt + 5'd1;
      else cnt <= '0;
    end
  end

endmodule

[hdl/wrp_dp.sv]
// Datapath for the WAV parser: chunk walk, fmt capture, final checks, output register.
// Depends on wrp_pkg.
module wrp_dp (
  input  logic              clk,
  input  logic              rst,
  input  wrp_pkg::wrp_cmd_t cmd,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic [7:0]        s_tdata,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [71:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast,
  output logic              out_free
);

  localparam int PW = wrp_pkg::PosW;
  localparam int EW = wrp_pkg::ExtW;

  // Configuration
  logic [31:0] max_file_bytes, max_data_bytes, min_rate_hz, max_rate_hz;
  logic [15:0] max_channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_file_bytes    <= 32'd16777216;
      max_data_bytes    <= 32'd16777216;
      max_channel_count <= 16'd2;
      min_rate_hz       <= 32'd8000;
      max_rate_hz       <= 32'd48000;
    end else if (cfg_we) begin
      case (cfg_index)
        wrp_pkg::REG_MAX_FILE: max_file_bytes    <= cfg_wdata;
        wrp_pkg::REG_MAX_DATA: max_data_bytes    <= cfg_wdata;
        wrp_pkg::REG_MAX_CH:   max_channel_count <= cfg_wdata[15:0];
        wrp_pkg::REG_MIN_RATE: min_rate_hz       <= cfg_wdata;
        wrp_pkg::REG_MAX_RATE: max_rate_hz       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parse state
  logic [PW-1:0] byte_position, riff_end_pos, chunk_start_pos;
  logic [31:0]   chunk_length, tag_shift, field_shift, data_length;
  logic [15:0]   fmt_code, fmt_channels, fmt_block_align, fmt_sample_bits;
  logic [31:0]   fmt_rate, fmt_byte_rate;
  logic          fmt_seen, data_seen, riff_ok, wave_ok, size_overflow;
  logic [7:0]    low_byte_hold;
  logic [4:0]    first_error;
  logic [1:0]    chunk_kind;

  logic [PW-1:0] byte_position_next, riff_end_pos_next, chunk_start_pos_next;
  logic [31:0]   chunk_length_next, tag_shift_next, field_shift_next, data_length_next;
  logic [15:0]   fmt_code_next, fmt_channels_next, fmt_block_align_next;
  logic [15:0]   fmt_sample_bits_next;
  logic [31:0]   fmt_rate_next, fmt_byte_rate_next;
  logic          fmt_seen_next, data_seen_next, riff_ok_next, wave_ok_next;
  logic          size_overflow_next;
  logic [7:0]    low_byte_hold_next;
  logic [4:0]    first_error_next, herr;
  logic [1:0]    chunk_kind_next;

  logic [31:0]   tag_sh, fld_sh;
  logic [EW-1:0] pe, cse, ree, rel, off, body, endp;
  logic          walk, samp_fire;
  logic [15:0]   samp;

  // One byte of the chunk walk
  always_comb begin
    byte_position_next   = byte_position;
    riff_end_pos_next    = riff_end_pos;
    chunk_start_pos_next = chunk_start_pos;
    chunk_length_next    = chunk_length;
    tag_shift_next       = tag_shift;
    field_shift_next     = field_shift;
    data_length_next     = data_length;
    fmt_code_next        = fmt_code;
    fmt_channels_next    = fmt_channels;
    fmt_block_align_next = fmt_block_align;
    fmt_sample_bits_next = fmt_sample_bits;
    fmt_rate_next        = fmt_rate;
    fmt_byte_rate_next   = fmt_byte_rate;
    fmt_seen_next        = fmt_seen;
    data_seen_next       = data_seen;
    riff_ok_next         = riff_ok;
    wave_ok_next         = wave_ok;
    size_overflow_next   = size_overflow;
    low_byte_hold_next   = low_byte_hold;
    first_error_next     = first_error;
    chunk_kind_next      = chunk_kind;
    samp_fire            = 1'b0;
    samp                 = {s_tdata, low_byte_hold};
    herr                 = wrp_pkg::ST_OK;

    tag_sh = {s_tdata, tag_shift[31:8]};
    fld_sh = {s_tdata, field_shift[31:8]};
    pe     = EW'(byte_position);
    cse    = EW'(chunk_start_pos);
    ree    = EW'(riff_end_pos);
    rel    = pe - cse;
    off    = rel - EW'(8);
    body   = cse + EW'(8);
    endp   = '0;
    walk   = (first_error == wrp_pkg::ST_OK) && (byte_position != wrp_pkg::PosMax) &&
             (pe >= cse) && (body <= ree);

    if (pe < EW'(wrp_pkg::HeaderBytes)) begin
      // File header: tags and RIFF size
      tag_shift_next = tag_sh;
      if (pe == EW'(3)) riff_ok_next = (tag_sh == wrp_pkg::TagRiff);
      if (pe == EW'(7)) begin
        if (EW'(tag_sh) > EW'(wrp_pkg::PosMax) - EW'(8)) begin
          size_overflow_next = 1'b1;
          riff_end_pos_next  = '0;
        end else begin
          riff_end_pos_next = PW'(EW'(tag_sh) + EW'(8));
        end
      end
      if (pe == EW'(11)) wave_ok_next = (tag_sh == wrp_pkg::TagWave);
    end else if (walk) begin
      if (rel < EW'(4)) begin
        tag_shift_next = tag_sh;
      end else if (rel < EW'(8)) begin
        field_shift_next = fld_sh;
        if (rel == EW'(7)) begin
          // Chunk header complete
          chunk_length_next = fld_sh;
          chunk_kind_next   = wrp_pkg::KIND_OTHER;
          if (EW'(fld_sh) > ree - body) begin
            herr = wrp_pkg::ST_CHUNK_OVER;
          end else if (tag_shift == wrp_pkg::TagFmt) begin
            if (fmt_seen) herr = wrp_pkg::ST_FMT_TWICE;
            else if (fld_sh < 32'(wrp_pkg::FmtMinBytes)) herr = wrp_pkg::ST_FMT_SHORT;
            else begin
              fmt_seen_next   = 1'b1;
              chunk_kind_next = wrp_pkg::KIND_FMT;
            end
          end else if (tag_shift == wrp_pkg::TagData) begin
            if (data_seen) herr = wrp_pkg::ST_DATA_TWICE;
            else if (fld_sh > max_data_bytes) herr = wrp_pkg::ST_DATA_BIG;
            else begin
              data_seen_next   = 1'b1;
              data_length_next = fld_sh;
              chunk_kind_next  = wrp_pkg::KIND_DATA;
            end
          end
          if (herr == wrp_pkg::ST_OK &&
              body + EW'(fld_sh) > ree - EW'(fld_sh[0]))
            herr = wrp_pkg::ST_PAD_OVER;
          if (herr != wrp_pkg::ST_OK) begin
            first_error_next = herr;
            chunk_kind_next  = wrp_pkg::KIND_OTHER;
          end
        end
      end else if (off < EW'(chunk_length)) begin
        // Chunk body
        if (chunk_kind == wrp_pkg::KIND_FMT && off < EW'(wrp_pkg::FmtMinBytes)) begin
          field_shift_next = fld_sh;
          case (off[3:0])
            4'd1:  fmt_code_next        = fld_sh[31:16];
            4'd3:  fmt_channels_next    = fld_sh[31:16];
            4'd7:  fmt_rate_next        = fld_sh;
            4'd11: fmt_byte_rate_next   = fld_sh;
            4'd13: fmt_block_align_next = fld_sh[31:16];
            4'd15: fmt_sample_bits_next = fld_sh[31:16];
            default: ;
          endcase
        end else if (chunk_kind == wrp_pkg::KIND_DATA) begin
          if (!off[0]) low_byte_hold_next = s_tdata;
          else samp_fire = 1'b1;
        end
      end
      // Advance to the next chunk after the body and pad byte
      endp = body + EW'(chunk_length_next) + EW'(chunk_length_next[0]);
      if (first_error_next == wrp_pkg::ST_OK && rel >= EW'(7) &&
          pe + EW'(1) == endp) begin
        chunk_start_pos_next = PW'(endp);
        chunk_kind_next      = wrp_pkg::KIND_OTHER;
      end
    end

    if (byte_position != wrp_pkg::PosMax) byte_position_next = byte_position + PW'(1);
  end

  // Parse state registers; cleared after each status
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      byte_position   <= '0;
      riff_end_pos    <= '0;
      chunk_start_pos <= PW'(wrp_pkg::HeaderBytes);
      chunk_length    <= '0;
      tag_shift       <= '0;
      field_shift     <= '0;
      data_length     <= '0;
      fmt_code        <= '0;
      fmt_channels    <= '0;
      fmt_block_align <= '0;
      fmt_sample_bits <= '0;
      fmt_rate        <= '0;
      fmt_byte_rate   <= '0;
      fmt_seen        <= 1'b0;
      data_seen       <= 1'b0;
      riff_ok         <= 1'b0;
      wave_ok         <= 1'b0;
      size_overflow   <= 1'b0;
      low_byte_hold   <= '0;
      first_error     <= wrp_pkg::ST_OK;
      chunk_kind      <= wrp_pkg::KIND_OTHER;
    end else if (cmd.accept) begin
      byte_position   <= byte_position_next;
      riff_end_pos    <= riff_end_pos_next;
      chunk_start_pos <= chunk_start_pos_next;
      chunk_length    <= chunk_length_next;
      tag_shift       <= tag_shift_next;
      field_shift     <= field_shift_next;
      data_length     <= data_length_next;
      fmt_code        <= fmt_code_next;
      fmt_channels    <= fmt_channels_next;
      fmt_block_align <= fmt_block_align_next;
      fmt_sample_bits <= fmt_sample_bits_next;
      fmt_rate        <= fmt_rate_next;
      fmt_byte_rate   <= fmt_byte_rate_next;
      fmt_seen        <= fmt_seen_next;
      data_seen       <= data_seen_next;
      riff_ok         <= riff_ok_next;
      wave_ok         <= wave_ok_next;
      size_overflow   <= size_overflow_next;
      low_byte_hold   <= low_byte_hold_next;
      first_error     <= first_error_next;
      chunk_kind      <= chunk_kind_next;
    end
  end

  // Early checks, in priority order
  logic [4:0]  pre_code, pre_code_next, fin_code;
  logic [15:0] expect_ba;
  logic [47:0] prod;
  logic [15:0] rem;
  logic [31:0] dvd;
  logic [16:0] trial;

  always_comb begin
    expect_ba = {fmt_channels[14:0], 1'b0};
    if (max_channel_count == '0 || max_rate_hz < min_rate_hz)
      pre_code_next = wrp_pkg::ST_LIMITS;
    else if (EW'(byte_position) > EW'(max_file_bytes) || byte_position == wrp_pkg::PosMax)
      pre_code_next = wrp_pkg::ST_TOO_LONG;
    else if (EW'(byte_position) < EW'(wrp_pkg::HeaderBytes))
      pre_code_next = wrp_pkg::ST_TOO_SHORT;
    else if (!riff_ok)       pre_code_next = wrp_pkg::ST_NO_RIFF;
    else if (!wave_ok)       pre_code_next = wrp_pkg::ST_NO_WAVE;
    else if (size_overflow)  pre_code_next = wrp_pkg::ST_SIZE_OVF;
    else if (riff_end_pos > byte_position) pre_code_next = wrp_pkg::ST_TRUNC;
    else if (EW'(riff_end_pos) < EW'(wrp_pkg::HeaderBytes))
      pre_code_next = wrp_pkg::ST_RIFF_SMALL;
    else if (first_error != wrp_pkg::ST_OK) pre_code_next = first_error;
    else if (!fmt_seen) pre_code_next = wrp_pkg::ST_NO_FMT;
    else if (fmt_code != wrp_pkg::PcmCode) pre_code_next = wrp_pkg::ST_NOT_PCM;
    else if (fmt_sample_bits != wrp_pkg::SampleBits) pre_code_next = wrp_pkg::ST_BITS;
    else if (fmt_channels == '0 || fmt_channels > max_channel_count)
      pre_code_next = wrp_pkg::ST_CHANNELS;
    else if (fmt_rate < min_rate_hz || fmt_rate > max_rate_hz)
      pre_code_next = wrp_pkg::ST_RATE;
    else if (fmt_block_align != expect_ba) pre_code_next = wrp_pkg::ST_ALIGN;
    else pre_code_next = wrp_pkg::ST_OK;
  end

  // Byte-rate product and bit-serial remainder of data length by block align
  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (cmd.chk_load) begin
      pre_code <= pre_code_next;
      prod     <= fmt_rate * expect_ba;
      rem      <= '0;
      dvd      <= data_length;
    end else if (cmd.div_step) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, fmt_block_align}) rem <= 16'(trial - {1'b0, fmt_block_align});
      else rem <= trial[15:0];
    end
  end

  // Late checks
  always_comb begin
    if (pre_code != wrp_pkg::ST_OK) fin_code = pre_code;
    else if (prod != {16'd0, fmt_byte_rate}) fin_code = wrp_pkg::ST_BYTE_RATE;
    else if (!data_seen) fin_code = wrp_pkg::ST_NO_DATA;
    else if (data_length == '0) fin_code = wrp_pkg::ST_DATA_EMPTY;
    else if (fmt_block_align == '0 || rem != '0) fin_code = wrp_pkg::ST_DATA_ALIGN;
    else fin_code = wrp_pkg::ST_OK;
  end

  // Output register
  logic load_samp;
  assign load_samp = cmd.accept && samp_fire;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_samp || cmd.emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_samp) begin
      m_tdata <= {3'd0, 32'd0, 16'd0, wrp_pkg::ST_OK, samp};
      m_tuser <= 1'b0;
      m_tlast <= 1'b0;
    end else if (cmd.emit) begin
      m_tdata <= {3'd0, fmt_rate, fmt_channels, fin_code, 16'd0};
      m_tuser <= 1'b1;
      m_tlast <= 1'b1;
    end
  end

endmodule

[hdl/wav_riff_pcm16_stream_parser.sv]
// Top level of the streaming RIFF/WAVE 16-bit PCM parser.
// Depends on wrp_pkg, wrp_ctrl, wrp_dp and the assertion header.
//
//  channel  | dir | signals                      | contents
//  s_       | in  | tvalid tready tdata tlast    | tdata[7:0] file byte, tlast final byte
//  m_       | out | tvalid tready tdata tuser    | sample or status, tlast end mark
//  cfg_     | in  | we index wdata               | limit registers 0..4
//
// One byte is taken per cycle while the output register is free.
// After the final byte the checks run (product, 32-step remainder, select)
// before the status is loaded; no byte is taken in that time.
// A stalled output holds intake. Reset is synchronous and restores the limit registers.
module wav_riff_pcm16_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] file_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [15:0] pcm_sample, [20:16] status_code,
                                 // [36:21] channel_count, [68:37] rate_hz, pad
  output logic        m_tuser,   // item_kind
  output logic        m_tlast,   // end_mark
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  wrp_pkg::wrp_cmd_t cmd;
  logic out_free;

  wrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .out_free (out_free),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  wrp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .out_free  (out_free)
  );

  // Checks
  `include "wav_riff_pcm16_stream_parser_assert.svh"

  `WRP_ASSERT_IMPLY(a_last_is_status, m_tvalid && m_tlast, m_tuser, "end mark on a sample")
  `WRP_ASSERT_IMPLY(a_sample_clean, m_tvalid && !m_tuser, m_tdata[68:16] == '0, "sample has status bits")
  `WRP_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "byte taken during checks")

endmodule

[test/tb_wav_riff_pcm16_stream_parser.sv]
// Self-checking testbench for the streaming WAV/PCM16 parser.
// Depends on wrp_pkg and the wav_riff_pcm16_stream_parser top level.
// Bytes of generated WAV files go in, samples and status are compared to a predictor.
module tb_wav_riff_pcm16_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;
  localparam int LongHold = 400;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint unsigned PosMaxL = (64'd1 << wrp_pkg::PosW) - 1;

  typedef struct {
    bit        kind;
    bit [15:0] sample;
    bit [4:0]  status;
    bit [15:0] chans;
    bit [31:0] rate;
    bit        endm;
  } wav_item_t;

  typedef struct {
    bit [7:0] b;
    bit       fin;
    bit       typed;
    bit [4:0] status;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  wav_riff_pcm16_stream_parser uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of limits and parse state
  bit [31:0] lim_file, lim_data, lim_min_rate, lim_max_rate;
  bit [15:0] lim_chans;
  longint unsigned pos, riff_stop, chunk_start;
  bit [31:0] chunk_len, tag_sh, field_sh, p_rate, p_byte_rate, data_len;
  bit [15:0] p_code, p_chans, p_align, p_bits;
  bit        fmt_seen, data_seen, riff_ok, wave_ok, size_ovf;
  bit [7:0]  low_hold;
  bit [4:0]  first_err;
  bit [1:0]  chunk_kind;

  wav_item_t expected_items[$];
  bit [7:0]  file_bytes[$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cnt = 0;
  int hold_req = 0;
  int hold_seen = 0;

  task automatic add_item(wav_item_t it);
    expected_items = {expected_items, it};
  endtask

  task automatic add_byte(bit [7:0] v);
    file_bytes = {file_bytes, v};
  endtask

  task automatic wav_clear();
    pos = 0; riff_stop = 0; chunk_start = wrp_pkg::HeaderBytes;
    chunk_len = 0; tag_sh = 0; field_sh = 0;
    p_code = 0; p_chans = 0; p_rate = 0; p_byte_rate = 0; p_align = 0; p_bits = 0;
    fmt_seen = 0; data_seen = 0; data_len = 0; low_hold = 0; first_err = 0;
    riff_ok = 0; wave_ok = 0; size_ovf = 0; chunk_kind = wrp_pkg::KIND_OTHER;
  endtask

  // expected results of one accepted byte
  task automatic wav_predict(bit [7:0] b, bit fin);
    longint unsigned p, rel, off, endp, body, cnt;
    bit [4:0]  err, st;
    bit [15:0] exp_align;
    wav_item_t it;
    p = pos;
    if (p < wrp_pkg::HeaderBytes) begin
      tag_sh = {b, tag_sh[31:8]};
      if (p == 3) riff_ok = (tag_sh == wrp_pkg::TagRiff);
      if (p == 7) begin
        if (64'(tag_sh) > PosMaxL - 8) begin
          size_ovf = 1; riff_stop = 0;
        end else riff_stop = 8 + 64'(tag_sh);
      end
      if (p == 11) wave_ok = (tag_sh == wrp_pkg::TagWave);
    end else if (first_err == 0 && p < PosMaxL && p >= chunk_start &&
                 chunk_start + 8 <= riff_stop) begin
      rel = p - chunk_start;
      if (rel < 4) begin
        tag_sh = {b, tag_sh[31:8]};
      end else if (rel < 8) begin
        field_sh = {b, field_sh[31:8]};
        if (rel == 7) begin
          // chunk header complete: size and kind checks
          body = chunk_start + 8;
          chunk_len = field_sh;
          chunk_kind = wrp_pkg::KIND_OTHER;
          err = wrp_pkg::ST_OK;
          if (64'(field_sh) > riff_stop - body) err = wrp_pkg::ST_CHUNK_OVER;
          else if (tag_sh == wrp_pkg::TagFmt) begin
            if (fmt_seen) err = wrp_pkg::ST_FMT_TWICE;
            else if (field_sh < wrp_pkg::FmtMinBytes) err = wrp_pkg::ST_FMT_SHORT;
            else begin
              fmt_seen = 1; chunk_kind = wrp_pkg::KIND_FMT;
            end
          end else if (tag_sh == wrp_pkg::TagData) begin
            if (data_seen) err = wrp_pkg::ST_DATA_TWICE;
            else if (field_sh > lim_data) err = wrp_pkg::ST_DATA_BIG;
            else begin
              data_seen = 1; data_len = field_sh; chunk_kind = wrp_pkg::KIND_DATA;
            end
          end
          if (err == wrp_pkg::ST_OK &&
              body + 64'(field_sh) > riff_stop - 64'(field_sh[0]))
            err = wrp_pkg::ST_PAD_OVER;
          if (err != wrp_pkg::ST_OK) begin
            first_err = err; chunk_kind = wrp_pkg::KIND_OTHER;
          end
        end
      end else begin
        off = rel - 8;
        if (off < 64'(chunk_len)) begin
          if (chunk_kind == wrp_pkg::KIND_FMT && off < wrp_pkg::FmtMinBytes) begin
            field_sh = {b, field_sh[31:8]};
            case (off)
              1: p_code = field_sh[31:16];
              3: p_chans = field_sh[31:16];
              7: p_rate = field_sh;
              11: p_byte_rate = field_sh;
              13: p_align = field_sh[31:16];
              15: p_bits = field_sh[31:16];
              default: ;
            endcase
          end else if (chunk_kind == wrp_pkg::KIND_DATA) begin
            if (off[0] == 1'b0) low_hold = b;
            else begin
              it = '{kind: 1'b0, sample: {b, low_hold}, status: wrp_pkg::ST_OK,
                     chans: 16'd0, rate: 32'd0, endm: 1'b0};
              add_item(it);
            end
          end
        end
      end
      if (first_err == 0 && rel >= 7) begin
        endp = chunk_start + 8 + 64'(chunk_len) + 64'(chunk_len[0]);
        if (p + 1 == endp) begin
          chunk_start = endp; chunk_kind = wrp_pkg::KIND_OTHER;
        end
      end
    end
    if (p < PosMaxL) pos = p + 1;

    if (fin) begin
      // final checks in fixed order
      cnt = pos;
      exp_align = 16'(32'(p_chans) * 2);
      if (lim_chans == 0 || lim_max_rate < lim_min_rate) st = wrp_pkg::ST_LIMITS;
      else if (cnt > 64'(lim_file) || cnt == PosMaxL) st = wrp_pkg::ST_TOO_LONG;
      else if (cnt < wrp_pkg::HeaderBytes) st = wrp_pkg::ST_TOO_SHORT;
      else if (!riff_ok) st = wrp_pkg::ST_NO_RIFF;
      else if (!wave_ok) st = wrp_pkg::ST_NO_WAVE;
      else if (size_ovf) st = wrp_pkg::ST_SIZE_OVF;
      else if (riff_stop > cnt) st = wrp_pkg::ST_TRUNC;
      else if (riff_stop < wrp_pkg::HeaderBytes) st = wrp_pkg::ST_RIFF_SMALL;
      else if (first_err != 0) st = first_err;
      else if (!fmt_seen) st = wrp_pkg::ST_NO_FMT;
      else if (p_code != wrp_pkg::PcmCode) st = wrp_pkg::ST_NOT_PCM;
      else if (p_bits != wrp_pkg::SampleBits) st = wrp_pkg::ST_BITS;
      else if (p_chans == 0 || p_chans > lim_chans) st = wrp_pkg::ST_CHANNELS;
      else if (p_rate < lim_min_rate || p_rate > lim_max_rate) st = wrp_pkg::ST_RATE;
      else if (p_align != exp_align) st = wrp_pkg::ST_ALIGN;
      else if (64'(p_rate) * 64'(exp_align) != 64'(p_byte_rate)) st = wrp_pkg::ST_BYTE_RATE;
      else if (!data_seen) st = wrp_pkg::ST_NO_DATA;
      else if (data_len == 0) st = wrp_pkg::ST_DATA_EMPTY;
      else if (p_align == 0 || data_len % p_align != 0) st = wrp_pkg::ST_DATA_ALIGN;
      else st = wrp_pkg::ST_OK;
      it = '{kind: 1'b1, sample: 16'd0, status: st, chans: p_chans, rate: p_rate,
             endm: 1'b1};
      add_item(it);
      wav_clear();
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    case (idx)
      wrp_pkg::REG_MAX_FILE: lim_file = val;
      wrp_pkg::REG_MAX_DATA: lim_data = val;
      wrp_pkg::REG_MAX_CH:   lim_chans = val[15:0];
      wrp_pkg::REG_MIN_RATE: lim_min_rate = val;
      wrp_pkg::REG_MAX_RATE: lim_max_rate = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(bit [31:0] mf, bit [31:0] md, bit [15:0] mc,
                            bit [31:0] mn, bit [31:0] mx);
    cfg_write(wrp_pkg::REG_MAX_FILE, mf);
    cfg_write(wrp_pkg::REG_MAX_DATA, md);
    cfg_write(wrp_pkg::REG_MAX_CH, 32'(mc));
    cfg_write(wrp_pkg::REG_MIN_RATE, mn);
    cfg_write(wrp_pkg::REG_MAX_RATE, mx);
  endtask

  // one byte transfer on the input side; called at a falling edge
  task automatic send_byte(bit [7:0] b, bit fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1; s_tdata = b; s_tlast = fin;
    do @(posedge clk); while (!s_tready);
    wav_predict(b, fin);
    @(negedge clk);
  endtask

  task automatic push32(bit [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
  endtask

  // random WAV file, mostly well formed; the header is added last
  task automatic build_wav();
    bit [7:0]  hdr[$];
    bit [15:0] ch, ba, code, bits;
    bit [31:0] rate, brate, riff_size;
    int n, roll;
    file_bytes = {};
    push32(wrp_pkg::TagWave);
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(0, 7);
      push32(32'h5453494C);
      push32(n);
      repeat (n + n % 2) add_byte($urandom);
    end
    repeat (($urandom_range(0, 15) == 0) ? 2 : (($urandom_range(0, 11) == 0) ? 0 : 1)) begin
      roll = $urandom_range(0, 19);
      n = (roll == 0) ? 14 : (roll < 4) ? 18 : 16;
      ch = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
      case ($urandom_range(0, 6))
        0: rate = 8000;
        1: rate = 44100;
        2: rate = 48000;
        3: rate = 7999;
        4: rate = 48001;
        5: rate = $urandom;
        default: rate = 22050;
      endcase
      code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wrp_pkg::PcmCode;
      bits = ($urandom_range(0, 9) == 0) ? 16'($urandom) : wrp_pkg::SampleBits;
      ba = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(ch * 2);
      brate = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'(rate * ba);
      push32(wrp_pkg::TagFmt);
      push32(n);
      hdr = {code[7:0], code[15:8], ch[7:0], ch[15:8], rate[7:0], rate[15:8],
             rate[23:16], rate[31:24], brate[7:0], brate[15:8], brate[23:16],
             brate[31:24], ba[7:0], ba[15:8], bits[7:0], bits[15:8]};
      for (int i = 0; i < n; i++) add_byte(i < 16 ? hdr[i] : 8'($urandom));
    end
    repeat (($urandom_range(0, 15) == 0) ? 2 : (($urandom_range(0, 11) == 0) ? 0 : 1)) begin
      n = $urandom_range(0, 40);
      push32(wrp_pkg::TagData);
      push32(n);
      repeat (n + n % 2) add_byte($urandom);
    end
    riff_size = file_bytes.size();
    case ($urandom_range(0, 19))
      0, 1: riff_size += $urandom_range(1, 8);
      2, 3: riff_size -= $urandom_range(1, 6);
      4: riff_size = $urandom_range(0, 3);
      5: riff_size = $urandom;
      default: ;
    endcase
    hdr = {8'h52, 8'h49, 8'h46, 8'h46, riff_size[7:0], riff_size[15:8],
           riff_size[23:16], riff_size[31:24]};
    for (int i = 7; i >= 0; i--) file_bytes.push_front(hdr[i]);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) add_byte($urandom);
    if ($urandom_range(0, 19) == 0)
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = $urandom;
  endtask

  // wait for all results, then the check latency, before touching registers
  task automatic drain();
    while (expected_items.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // receiver side ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt  <= LongHold - 1;
      m_tready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // output transfer check against the oldest expectation
  always @(posedge clk) begin
    wav_item_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_items.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected output tdata=%h tuser=%b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        e = expected_items.pop_front();
        if (m_tuser !== e.kind || m_tdata[15:0] !== e.sample || m_tdata[20:16] !== e.status ||
            m_tdata[36:21] !== e.chans || m_tdata[68:37] !== e.rate ||
            m_tlast !== e.endm) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch exp kind=%0d smp=%h st=%0d ch=%0d rate=%0d end=%0d | ",
                     e.kind, e.sample, e.status, e.chans, e.rate, e.endm,
                     "got kind=%0d smp=%h st=%0d ch=%0d rate=%0d end=%0d",
                     m_tuser, m_tdata[15:0], m_tdata[20:16], m_tdata[36:21],
                     m_tdata[68:37], m_tlast);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_wav_riff_pcm16_stream_parser: FAIL");
      $finish;
    end
  end

  // directed files: one byte, minimal header without fmt, truncated RIFF payload
  byte_row_t directed_rows[25] = '{
    '{8'h00, 1, 1, wrp_pkg::ST_TOO_SHORT},
    '{8'h52, 0, 0, wrp_pkg::ST_OK}, '{8'h49, 0, 0, wrp_pkg::ST_OK},
    '{8'h46, 0, 0, wrp_pkg::ST_OK}, '{8'h46, 0, 0, wrp_pkg::ST_OK},
    '{8'h04, 0, 0, wrp_pkg::ST_OK}, '{8'h00, 0, 0, wrp_pkg::ST_OK},
    '{8'h00, 0, 0, wrp_pkg::ST_OK}, '{8'h00, 0, 0, wrp_pkg::ST_OK},
    '{8'h57, 0, 0, wrp_pkg::ST_OK}, '{8'h41, 0, 0, wrp_pkg::ST_OK},
    '{8'h56, 0, 0, wrp_pkg::ST_OK}, '{8'h45, 1, 1, wrp_pkg::ST_NO_FMT},
    '{8'h52, 0, 0, wrp_pkg::ST_OK}, '{8'h49, 0, 0, wrp_pkg::ST_OK},
    '{8'h46, 0, 0, wrp_pkg::ST_OK}, '{8'h46, 0, 0, wrp_pkg::ST_OK},
    '{8'hFF, 0, 0, wrp_pkg::ST_OK}, '{8'hFF, 0, 0, wrp_pkg::ST_OK},
    '{8'hFF, 0, 0, wrp_pkg::ST_OK}, '{8'hFF, 0, 0, wrp_pkg::ST_OK},
    '{8'h57, 0, 0, wrp_pkg::ST_OK}, '{8'h41, 0, 0, wrp_pkg::ST_OK},
    '{8'h56, 0, 0, wrp_pkg::ST_OK}, '{8'h45, 1, 1, wrp_pkg::ST_TRUNC}
  };

  initial begin
    int sent;
    lim_file = 32'd16777216; lim_data = 32'd16777216; lim_chans = 16'd2;
    lim_min_rate = 32'd8000; lim_max_rate = 32'd48000;
    wav_clear();
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed part with reset limits; typed rows override the predictor
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b, directed_rows[i].fin);
      if (directed_rows[i].typed) begin
        expected_items[$].status = directed_rows[i].status;
        expected_items[$].chans = 16'd0;
        expected_items[$].rate = 32'd0;
      end
    end
    s_tvalid = 1'b0;
    drain();

    // random files over several limit settings and idle patterns
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: set_limits('1, '1, '1, '0, '1);
        2: set_limits(32'd70, 32'd10, 16'd1, 32'd8000, 32'd8000);
        3: begin
          set_limits(32'd16777216, 32'd16777216, 16'd2, 32'd8000, 32'd48000);
          cfg_write(REG_UNUSED, $urandom);
        end
        4: cfg_write(wrp_pkg::REG_MAX_CH, 32'd0);
        5: set_limits(32'd0, 32'd40, 16'd2, 32'd50000, 32'd40000);
        default: ;
      endcase
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      if (phase == 1) begin
        tx_idle_pct = 0;
        @(posedge clk);
        hold_req++;
        @(negedge clk);
      end
      sent = 0;
      while (sent < ((phase < 4) ? 150 : 50)) begin
        build_wav();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
        sent += file_bytes.size();
        if (phase == 1) tx_idle_pct = 70;
        // occasional idle gaps that let all expected results drain
        if ($urandom_range(0, 3) == 0) begin
          s_tvalid = 1'b0;
          drain();
        end
      end
      s_tvalid = 1'b0;
      drain();
    end

    if (errors == 0 && expected_items.size() == 0) begin
      $display("tb_wav_riff_pcm16_stream_parser: PASS");
    end else begin
      $display("tb_wav_riff_pcm16_stream_parser: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/wrp_pkg.sv
hdl/wrp_ctrl.sv
hdl/wrp_dp.sv
hdl/wav_riff_pcm16_stream_parser.sv
test/tb_wav_riff_pcm16_stream_parser.sv
